[hw/rtl/rscg_pkg.sv]
// shared types, constants and table functions for the rotary sin/cos generator
package rscg_pkg;

  localparam int POSITION_W    = 12;
  localparam int INDEX_W       = 8;
  localparam int HEAD_W        = 9;
  localparam int RESULT_W      = 32;
  localparam int MAX_HEAD_SIZE = 256;
  localparam logic [HEAD_W-1:0] HEAD_LEN_RESET = 9'd128;

  localparam int QUOT_W     = 32;
  localparam int DIV_STAGES = 4;
  localparam int PROD_W     = 64;
  localparam int EXP_N_W    = 4;
  localparam int FREQ_W     = 33;
  localparam int POW_STEPS  = 32;
  localparam int ANGLE_W    = 57;
  localparam int MOD_STEPS  = 10;
  localparam int CORDIC_W   = 44;
  localparam int CORDIC_STEPS = 40;

  localparam logic [31:0] LOG2_1E4_Q28 = 32'd3566893132;
  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;

  localparam logic [ANGLE_W-1:0] TWO_PI_Q44 = ANGLE_W'((PI_Q60 + 64'd16384) >> 15);
  localparam logic signed [CORDIC_W-1:0] PI_Q40 =
    CORDIC_W'((PI_Q60 + 64'd524288) >> 20);
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q40 =
    CORDIC_W'((PI_Q60 + 64'd1048576) >> 21);
  localparam logic signed [CORDIC_W-1:0] TWO_PI_Q40 =
    CORDIC_W'((PI_Q60 + 64'd262144) >> 19);
  localparam logic signed [CORDIC_W-1:0] GAIN_Q40 = CORDIC_W'(64'd652032874 << 10);

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic [INDEX_W-1:0]    element_index;
  } item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] sine_value;
    logic signed [RESULT_W-1:0] cosine_value;
    logic                       index_fault;
  } result_t;

  typedef struct packed {
    logic [QUOT_W-1:0]     quot;
    logic [POSITION_W-1:0] position;
    logic                  fault;
  } quot_t;

  typedef struct packed {
    logic [FREQ_W-1:0]     freq;
    logic [POSITION_W-1:0] position;
    logic                  fault;
  } freq_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] z;
    logic                       neg;
    logic                       fault;
  } angle_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    rem = v;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in q0.32
  function automatic logic [31:0] pow_factor(input int k);
    logic [63:0] p;
    p = isqrt64(64'd1 << 63);
    for (int i = 2; i <= k; i++) p = isqrt64(p << 32);
    return p[31:0];
  endfunction

  // arctangent of 2^-k in q40
  function automatic logic signed [CORDIC_W-1:0] atan_q40(input int k);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    int e;
    int j;
    sum = '0;
    if (k == 0) begin
      r = (PI_Q60 + 64'd2097152) >> 22;
    end else begin
      e = 62 - k;
      j = 0;
      while (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * j + 1);
        if ((j & 1) == 0) sum = sum + term;
        else sum = sum - term;
        j = j + 1;
        e = e - 2 * k;
      end
      r = (sum + 64'd2097152) >> 22;
    end
    return r[CORDIC_W-1:0];
  endfunction

endpackage

[hw/rtl/rscg_divider.sv]
// pipelined restoring divider: even index scaled by 2^32 over head size
module rscg_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rscg_pkg::HEAD_W-1:0]     head_len,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rscg_pkg::item_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rscg_pkg::quot_t                 out_data
);
  localparam int Stages = rscg_pkg::DIV_STAGES;
  localparam int Steps  = rscg_pkg::QUOT_W / Stages;
  localparam int HW     = rscg_pkg::HEAD_W;
  localparam int QW     = rscg_pkg::QUOT_W;
  localparam int PW     = rscg_pkg::POSITION_W;

  logic [Stages-1:0] valid;
  logic [Stages:0]   rdy;
  logic [Stages-1:0] vin;

  logic [HW-1:0] rem       [Stages];
  logic [QW-1:0] quot      [Stages];
  logic [PW-1:0] position  [Stages];
  logic          fault     [Stages];
  logic [HW-1:0] src_rem   [Stages];
  logic [QW-1:0] src_quot  [Stages];
  logic [PW-1:0] src_pos   [Stages];
  logic          src_fault [Stages];
  logic [HW-1:0] rem_next  [Stages];
  logic [QW-1:0] quot_next [Stages];

  assign rdy[Stages] = out_ready;
  assign vin         = {valid[Stages-2:0], in_valid};
  assign in_ready    = rdy[0];
  assign out_valid   = valid[Stages-1];
  assign out_data    = '{quot: quot[Stages-1], position: position[Stages-1],
                         fault: fault[Stages-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (rdy[s]) valid[s] <= vin[s];
      end
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    assign rdy[s] = !valid[s] || rdy[s+1];

    if (s == 0) begin : g_head
      assign src_rem[s]   = {1'b0, in_data.element_index[rscg_pkg::INDEX_W-1:1], 1'b0};
      assign src_quot[s]  = '0;
      assign src_pos[s]   = in_data.position;
      assign src_fault[s] = ({1'b0, in_data.element_index} >= head_len);
    end else begin : g_body
      assign src_rem[s]   = rem[s-1];
      assign src_quot[s]  = quot[s-1];
      assign src_pos[s]   = position[s-1];
      assign src_fault[s] = fault[s-1];
    end

    always_comb begin : p_steps
      logic [HW:0]   r2;
      logic [HW-1:0] r;
      logic [QW-1:0] q;
      r = src_rem[s];
      q = src_quot[s];
      for (int i = 0; i < Steps; i++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, head_len}) begin
          r2 = r2 - {1'b0, head_len};
          q  = {q[QW-2:0], 1'b1};
        end else begin
          q  = {q[QW-2:0], 1'b0};
        end
        r = r2[HW-1:0];
      end
      rem_next[s]  = r;
      quot_next[s] = q;
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem[s]      <= rem_next[s];
        quot[s]     <= quot_next[s];
        position[s] <= src_pos[s];
        fault[s]    <= src_fault[s];
      end
    end
  end

endmodule

[hw/rtl/rscg_exponent.sv]
// frequency pipeline: exponent scaling, 2^-f product chain and integer shift
module rscg_exponent (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rscg_pkg::quot_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rscg_pkg::freq_t out_data
);
  localparam int Pow    = rscg_pkg::POW_STEPS;
  localparam int Stages = Pow + 3;
  localparam int PW     = rscg_pkg::POSITION_W;
  localparam int FW     = rscg_pkg::FREQ_W;
  localparam int NW     = rscg_pkg::EXP_N_W;
  localparam int XW     = rscg_pkg::PROD_W;

  logic [Stages-1:0] valid;
  logic [Stages:0]   rdy;
  logic [Stages-1:0] vin;

  // product stage
  logic [XW-1:0] prod;
  logic [PW-1:0] prod_pos;
  logic          prod_fault;
  // split stage
  logic [XW-1:0] prod_rnd;
  logic [NW-1:0] split_n;
  logic [Pow-1:0] split_f;
  logic [PW-1:0] split_pos;
  logic          split_fault;
  // product chain
  logic [FW-1:0]  pw_m     [Pow];
  logic [Pow-1:0] pw_f     [Pow];
  logic [NW-1:0]  pw_n     [Pow];
  logic [PW-1:0]  pw_pos   [Pow];
  logic           pw_fault [Pow];
  logic [FW-1:0]  pw_m_next [Pow];
  // shift stage
  logic [FW:0]   freq_rnd;
  logic [FW-1:0] freq_next;
  logic [FW-1:0] freq;
  logic [PW-1:0] freq_pos;
  logic          freq_fault;

  assign rdy[Stages] = out_ready;
  assign vin         = {valid[Stages-2:0], in_valid};
  assign in_ready    = rdy[0];
  assign out_valid   = valid[Stages-1];
  assign out_data    = '{freq: freq, position: freq_pos, fault: freq_fault};

  for (genvar s = 0; s < Stages; s++) begin : g_rdy
    assign rdy[s] = !valid[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (rdy[s]) valid[s] <= vin[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod       <= XW'(in_data.quot) * XW'(rscg_pkg::LOG2_1E4_Q28);
      prod_pos   <= in_data.position;
      prod_fault <= in_data.fault;
    end
  end

  assign prod_rnd = prod + (XW'(1) << 27);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      split_n     <= prod_rnd[XW-1:XW-NW];
      split_f     <= prod_rnd[XW-NW-1:28];
      split_pos   <= prod_pos;
      split_fault <= prod_fault;
    end
  end

  for (genvar i = 0; i < Pow; i++) begin : g_pow
    localparam logic [31:0] Factor = rscg_pkg::pow_factor(i + 1);
    logic [FW-1:0]  src_m;
    logic [Pow-1:0] src_f;
    logic [NW-1:0]  src_n;
    logic [PW-1:0]  src_pos;
    logic           src_fault;
    logic [FW+31:0] mul;
    logic [FW+31:0] mul_rnd;

    if (i == 0) begin : g_head
      assign src_m     = FW'(1) << 32;
      assign src_f     = split_f;
      assign src_n     = split_n;
      assign src_pos   = split_pos;
      assign src_fault = split_fault;
    end else begin : g_body
      assign src_m     = pw_m[i-1];
      assign src_f     = pw_f[i-1];
      assign src_n     = pw_n[i-1];
      assign src_pos   = pw_pos[i-1];
      assign src_fault = pw_fault[i-1];
    end

    assign mul          = (FW+32)'(src_m) * (FW+32)'(Factor);
    assign mul_rnd      = mul + ((FW+32)'(1) << 31);
    assign pw_m_next[i] = src_f[Pow-1-i] ? mul_rnd[FW+31:32] : src_m;

    always_ff @(posedge clk) begin
      if (rdy[i+2]) begin
        pw_m[i]     <= pw_m_next[i];
        pw_f[i]     <= src_f;
        pw_n[i]     <= src_n;
        pw_pos[i]   <= src_pos;
        pw_fault[i] <= src_fault;
      end
    end
  end

  always_comb begin
    if (pw_n[Pow-1] == '0) begin
      freq_rnd = {1'b0, pw_m[Pow-1]};
    end else begin
      freq_rnd = {1'b0, pw_m[Pow-1]} + ((FW+1)'(1) << (pw_n[Pow-1] - NW'(1)));
    end
    freq_next = FW'(freq_rnd >> pw_n[Pow-1]);
  end

  always_ff @(posedge clk) begin
    if (rdy[Stages-1]) begin
      freq       <= freq_next;
      freq_pos   <= pw_pos[Pow-1];
      freq_fault <= pw_fault[Pow-1];
    end
  end

endmodule

[hw/rtl/rscg_angle.sv]
// angle pipeline: position times frequency, reduction mod 2*pi, quadrant fold
module rscg_angle (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rscg_pkg::freq_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rscg_pkg::angle_t out_data
);
  localparam int Mods   = rscg_pkg::MOD_STEPS;
  localparam int Stages = Mods + 4;
  localparam int AW     = rscg_pkg::ANGLE_W;
  localparam int PW     = rscg_pkg::POSITION_W;
  localparam int FW     = rscg_pkg::FREQ_W;
  localparam int CW     = rscg_pkg::CORDIC_W;

  logic [Stages-1:0] valid;
  logic [Stages:0]   rdy;
  logic [Stages-1:0] vin;

  logic [AW-1:0] ang;
  logic          ang_fault;
  logic [AW-1:0] md_r     [Mods];
  logic          md_fault [Mods];

  logic [AW-1:0]          z_sum;
  logic signed [CW-1:0]   z0;
  logic                   z0_fault;
  logic signed [CW-1:0]   z1;
  logic                   z1_fault;
  logic signed [CW-1:0]   z2;
  logic                   z2_neg;
  logic                   z2_fault;

  assign rdy[Stages] = out_ready;
  assign vin         = {valid[Stages-2:0], in_valid};
  assign in_ready    = rdy[0];
  assign out_valid   = valid[Stages-1];
  assign out_data    = '{z: z2, neg: z2_neg, fault: z2_fault};

  for (genvar s = 0; s < Stages; s++) begin : g_rdy
    assign rdy[s] = !valid[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (rdy[s]) valid[s] <= vin[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ang       <= {(PW+FW)'(in_data.position) * (PW+FW)'(in_data.freq), 12'b0};
      ang_fault <= in_data.fault;
    end
  end

  for (genvar i = 0; i < Mods; i++) begin : g_mod
    localparam logic [AW-1:0] Step = rscg_pkg::TWO_PI_Q44 << (Mods - 1 - i);
    logic [AW-1:0] src_r;
    logic          src_fault;

    if (i == 0) begin : g_head
      assign src_r     = ang;
      assign src_fault = ang_fault;
    end else begin : g_body
      assign src_r     = md_r[i-1];
      assign src_fault = md_fault[i-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        md_r[i]     <= (src_r >= Step) ? src_r - Step : src_r;
        md_fault[i] <= src_fault;
      end
    end
  end

  assign z_sum = md_r[Mods-1] + AW'(8);

  always_ff @(posedge clk) begin
    if (rdy[Mods+1]) begin
      z0       <= {1'b0, z_sum[CW+2:4]};
      z0_fault <= md_fault[Mods-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[Mods+2]) begin
      z1       <= (z0 > rscg_pkg::PI_Q40) ? z0 - rscg_pkg::TWO_PI_Q40 : z0;
      z1_fault <= z0_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[Mods+3]) begin
      if (z1 > rscg_pkg::HALF_PI_Q40) begin
        z2     <= z1 - rscg_pkg::PI_Q40;
        z2_neg <= 1'b1;
      end else if (z1 < -rscg_pkg::HALF_PI_Q40) begin
        z2     <= z1 + rscg_pkg::PI_Q40;
        z2_neg <= 1'b1;
      end else begin
        z2     <= z1;
        z2_neg <= 1'b0;
      end
      z2_fault <= z1_fault;
    end
  end

endmodule

[hw/rtl/rscg_cordic.sv]
// rotation-mode cordic, one iteration per stage, with q2.30 output register
module rscg_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rscg_pkg::angle_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rscg_pkg::result_t out_data
);
  localparam int Iters  = rscg_pkg::CORDIC_STEPS;
  localparam int Stages = Iters + 1;
  localparam int CW     = rscg_pkg::CORDIC_W;
  localparam int RW     = rscg_pkg::RESULT_W;

  logic [Stages-1:0] valid;
  logic [Stages:0]   rdy;
  logic [Stages-1:0] vin;

  logic signed [CW-1:0] cx    [Iters];
  logic signed [CW-1:0] cy    [Iters];
  logic signed [CW-1:0] cz    [Iters];
  logic                 neg   [Iters];
  logic                 fault [Iters];

  logic signed [CW-1:0] fin_x;
  logic signed [CW-1:0] fin_y;
  rscg_pkg::result_t    result;

  function automatic logic [RW-1:0] to_q30(input logic signed [CW-1:0] v);
    logic signed [CW:0] s;
    logic signed [CW:0] r;
    s = {v[CW-1], v} + (CW+1)'(512);
    r = s >>> 10;
    if (r > ((CW+1)'(1) << 30)) r = (CW+1)'(1) << 30;
    if (r < -((CW+1)'(1) << 30)) r = -((CW+1)'(1) << 30);
    return r[RW-1:0];
  endfunction

  assign rdy[Stages] = out_ready;
  assign vin         = {valid[Stages-2:0], in_valid};
  assign in_ready    = rdy[0];
  assign out_valid   = valid[Stages-1];
  assign out_data    = result;

  for (genvar s = 0; s < Stages; s++) begin : g_rdy
    assign rdy[s] = !valid[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (rdy[s]) valid[s] <= vin[s];
      end
    end
  end

  for (genvar k = 0; k < Iters; k++) begin : g_iter
    localparam logic signed [CW-1:0] Atan = rscg_pkg::atan_q40(k);
    logic signed [CW-1:0] src_x;
    logic signed [CW-1:0] src_y;
    logic signed [CW-1:0] src_z;
    logic                 src_neg;
    logic                 src_fault;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (k == 0) begin : g_head
      assign src_x     = rscg_pkg::GAIN_Q40;
      assign src_y     = '0;
      assign src_z     = in_data.z;
      assign src_neg   = in_data.neg;
      assign src_fault = in_data.fault;
    end else begin : g_body
      assign src_x     = cx[k-1];
      assign src_y     = cy[k-1];
      assign src_z     = cz[k-1];
      assign src_neg   = neg[k-1];
      assign src_fault = fault[k-1];
    end

    assign dx = src_y >>> k;
    assign dy = src_x >>> k;

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        if (src_z >= 0) begin
          cx[k] <= src_x - dx;
          cy[k] <= src_y + dy;
          cz[k] <= src_z - Atan;
        end else begin
          cx[k] <= src_x + dx;
          cy[k] <= src_y - dy;
          cz[k] <= src_z + Atan;
        end
        neg[k]   <= src_neg;
        fault[k] <= src_fault;
      end
    end
  end

  assign fin_x = neg[Iters-1] ? -cx[Iters-1] : cx[Iters-1];
  assign fin_y = neg[Iters-1] ? -cy[Iters-1] : cy[Iters-1];

  always_ff @(posedge clk) begin
    if (rdy[Stages-1]) begin
      if (fault[Iters-1]) begin
        result <= '{sine_value: '0, cosine_value: '0, index_fault: 1'b1};
      end else begin
        result <= '{sine_value: to_q30(fin_y), cosine_value: to_q30(fin_x),
                    index_fault: 1'b0};
      end
    end
  end

endmodule

[hw/rtl/rotary_sin_cos_generator.sv]
// top level of the rotary position embedding sine/cosine generator
//
//   channel  direction  handshake                   payload
//   item     in         item_valid / item_stall     item_data (position, element_index)
//   result   out        result_valid / result_stall result_data (sine, cosine, fault)
//   config   in         config_write                config_data (head size)
//
// one transaction per cycle sustained while result_stall is low
// the 40-step cordic and the 32-step 2^-f multiply chain set the pipeline depth
// each stage holds while the stage after it is full and stalled, bubbles are filled
// synchronous reset empties every stage and sets the head size to 128
module rotary_sin_cos_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  rscg_pkg::item_t              item_data,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rscg_pkg::result_t            result_data,
  input  logic                         config_write,
  input  logic [rscg_pkg::HEAD_W-1:0]  config_data
);
  localparam logic [rscg_pkg::HEAD_W-1:0] HeadMax = rscg_pkg::HEAD_W'(rscg_pkg::MAX_HEAD_SIZE);

  logic [rscg_pkg::HEAD_W-1:0] head_len;
  logic                        item_ready;
  logic                        div_valid;
  logic                        div_ready;
  rscg_pkg::quot_t             div_data;
  logic                        exp_valid;
  logic                        exp_ready;
  rscg_pkg::freq_t             exp_data;
  logic                        ang_valid;
  logic                        ang_ready;
  rscg_pkg::angle_t            ang_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_len <= rscg_pkg::HEAD_LEN_RESET;
    end else if (config_write) begin
      head_len <= (config_data > HeadMax) ? HeadMax : config_data;
    end
  end

  assign item_stall = !item_ready;

  rscg_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .head_len  (head_len),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_data   (item_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  rscg_exponent u_exponent (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (exp_valid),
    .out_ready (exp_ready),
    .out_data  (exp_data)
  );

  rscg_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exp_valid),
    .in_ready  (exp_ready),
    .in_data   (exp_data),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_data  (ang_data)
  );

  rscg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_data   (ang_data),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_data  (result_data)
  );

endmodule

[verif/rotary_sin_cos_generator_test.sv]
// testbench for the rotary sin/cos generator with a self-checking scoreboard
`timescale 1ns / 1ps

module rotary_sin_cos_generator_test;

  class sin_cos_scoreboard;
    logic [63:0] pow_factors [33];
    longint atan_steps [rscg_pkg::CORDIC_STEPS];
    logic [rscg_pkg::HEAD_W-1:0] head_len;
    rscg_pkg::result_t expected_results [$];
    int mismatches;
    int results_checked;
    int faults_seen;

    function new();
      longint sum;
      longint term;
      int e;
      int j;
      head_len = rscg_pkg::HEAD_LEN_RESET;
      mismatches = 0;
      results_checked = 0;
      faults_seen = 0;
      pow_factors[0] = '0;
      pow_factors[1] = int_sqrt(64'd1 << 63);
      for (int k = 2; k <= 32; k++) pow_factors[k] = int_sqrt(pow_factors[k-1] << 32);
      atan_steps[0] = longint'((rscg_pkg::PI_Q60 + (64'd1 << 21)) >> 22);
      for (int k = 1; k < rscg_pkg::CORDIC_STEPS; k++) begin
        sum = 0;
        e = 62 - k;
        j = 0;
        while (e >= 0) begin
          term = longint'((64'd1 << e) / 64'(2 * j + 1));
          if ((j % 2) == 0) sum = sum + term;
          else sum = sum - term;
          j++;
          e = e - 2 * k;
        end
        atan_steps[k] = longint'((64'(sum) + (64'd1 << 21)) >> 22);
      end
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 64'd0) begin
        if (v >= root + probe) begin
          v = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function void set_head_len(logic [rscg_pkg::HEAD_W-1:0] v);
      head_len = (v > rscg_pkg::MAX_HEAD_SIZE) ?
                 rscg_pkg::HEAD_W'(rscg_pkg::MAX_HEAD_SIZE) : v;
    endfunction

    function logic signed [rscg_pkg::RESULT_W-1:0] round_q30(longint v);
      longint q;
      q = (v + 512) >>> 10;
      if (q > (64'sd1 <<< 30)) q = 64'sd1 <<< 30;
      if (q < -(64'sd1 <<< 30)) q = -(64'sd1 <<< 30);
      return q[rscg_pkg::RESULT_W-1:0];
    endfunction

    function rscg_pkg::result_t compute_sin_cos(rscg_pkg::item_t it);
      rscg_pkg::result_t res;
      logic [63:0] pos, even_idx, expo, t, frac, mant, freq, ang, r;
      int n;
      longint z, cx, cy, dx, dy;
      bit neg;
      res = '0;
      if (it.element_index >= head_len) begin
        res.index_fault = 1'b1;
        return res;
      end
      pos = 64'(it.position);
      even_idx = 64'({it.element_index[rscg_pkg::INDEX_W-1:1], 1'b0});
      expo = (even_idx << 32) / 64'(head_len);
      t = (expo * 64'(rscg_pkg::LOG2_1E4_Q28) + (64'd1 << 27)) >> 28;
      n = int'(t >> 32);
      frac = {32'd0, t[31:0]};
      mant = 64'd1 << 32;
      for (int k = 1; k <= 32; k++)
        if (frac[32-k]) mant = (mant * pow_factors[k] + (64'd1 << 31)) >> 32;
      freq = (n == 0) ? mant : ((mant + (64'd1 << (n - 1))) >> n);
      ang = (pos * freq) << 12;
      r = ang % 64'(rscg_pkg::TWO_PI_Q44);
      z = longint'((r + 8) >> 4);
      neg = 0;
      if (z > longint'(rscg_pkg::PI_Q40)) z = z - longint'(rscg_pkg::TWO_PI_Q40);
      if (z > longint'(rscg_pkg::HALF_PI_Q40)) begin
        z = z - longint'(rscg_pkg::PI_Q40);
        neg = 1;
      end else if (z < -longint'(rscg_pkg::HALF_PI_Q40)) begin
        z = z + longint'(rscg_pkg::PI_Q40);
        neg = 1;
      end
      cx = longint'(rscg_pkg::GAIN_Q40);
      cy = 0;
      for (int k = 0; k < rscg_pkg::CORDIC_STEPS; k++) begin
        dx = cy >>> k;
        dy = cx >>> k;
        if (z >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - atan_steps[k];
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + atan_steps[k];
        end
      end
      if (neg) begin
        cx = -cx;
        cy = -cy;
      end
      res.sine_value = round_q30(cy);
      res.cosine_value = round_q30(cx);
      return res;
    endfunction

    function void note_item(rscg_pkg::item_t it);
      expected_results.insert(expected_results.size(), compute_sin_cos(it));
    endfunction

    function void check_result(rscg_pkg::result_t got);
      rscg_pkg::result_t want;
      results_checked++;
      if (got.index_fault) faults_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.sine_value !== want.sine_value || got.cosine_value !== want.cosine_value ||
          got.index_fault !== want.index_fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected sin %0d cos %0d fault %0d,",
                    " got sin %0d cos %0d fault %0d"},
                   want.sine_value, want.cosine_value, want.index_fault,
                   got.sine_value, got.cosine_value, got.index_fault);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  rscg_pkg::item_t item_data;
  logic result_valid;
  logic result_stall;
  rscg_pkg::result_t result_data;
  logic config_write;
  logic [rscg_pkg::HEAD_W-1:0] config_data;

  sin_cos_scoreboard sb;
  int cycle_count;
  bit no_idling;
  bit long_hold_request;
  int hold_left;
  int stall_left;
  int items_sent;

  rotary_sin_cos_generator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
    .result_valid(result_valid), .result_stall(result_stall), .result_data(result_data),
    .config_write(config_write), .config_data(config_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idling || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: sample, then decide the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_data);
    if (long_hold_request) begin
      long_hold_request = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      result_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_item(logic [rscg_pkg::POSITION_W-1:0] pos,
                           logic [rscg_pkg::INDEX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data <= '{position: pos, element_index: idx};
    do @(posedge clk); while (item_stall);
    sb.note_item(item_data);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_head_len(logic [rscg_pkg::HEAD_W-1:0] v);
    config_write <= 1'b1;
    config_data <= v;
    @(posedge clk);
    sb.set_head_len(v);
    config_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [rscg_pkg::POSITION_W-1:0] pos;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: pos = '1;
        1: pos = '0;
        default: pos = rscg_pkg::POSITION_W'($urandom_range(0, 4095));
      endcase
      send_item(pos, rscg_pkg::INDEX_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    no_idling = 0;
    long_hold_request = 0;
    hold_left = 0;
    stall_left = 0;
    items_sent = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item_data <= '0;
    result_stall <= 1'b0;
    config_write <= 1'b0;
    config_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset head size
    send_item(12'd0, 8'd0);
    send_item(12'd4095, 8'd0);
    send_item(12'd4095, 8'd1);
    send_item(12'd1, 8'd2);
    send_item(12'd4095, 8'd126);
    send_item(12'd4095, 8'd127);
    send_item(12'd100, 8'd128);
    send_item(12'd4095, 8'd255);
    send_item(12'd2048, 8'd64);
    send_item(12'd3000, 8'd85);
    drain();
    write_head_len(9'd256);
    send_item(12'd4095, 8'd254);
    send_item(12'd4095, 8'd255);
    drain();
    write_head_len(9'd0);
    send_item(12'd4095, 8'd0);
    send_item(12'd0, 8'd0);
    drain();
    write_head_len(9'd1);
    send_item(12'd4095, 8'd0);
    send_item(12'd4095, 8'd1);
    drain();
    write_head_len(9'd511);
    send_item(12'd4095, 8'd255);
    drain();
    write_head_len(9'd300);
    send_item(12'd1234, 8'd200);
    drain();

    // long receiver hold while items keep coming
    write_head_len(9'd64);
    no_idling = 1;
    long_hold_request = 1;
    send_random(200);
    no_idling = 0;
    drain();

    write_head_len(9'd2);
    send_random(40);
    drain();
    write_head_len(9'd3);
    send_random(40);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_head_len(rscg_pkg::HEAD_W'($urandom_range(2, 256)));
      no_idling = (p == 2);
      send_random(80);
      drain();
    end

    $display("covered %0d items over head sizes 0, 1, 2, 3, 64, 128, 256, saturated and random",
             items_sent);
    $display("%0d results checked, %0d index faults, %0d mismatches",
             sb.results_checked, sb.faults_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[rotary_sin_cos_generator.f]
hw/rtl/rscg_pkg.sv
hw/rtl/rscg_divider.sv
hw/rtl/rscg_exponent.sv
hw/rtl/rscg_angle.sv
hw/rtl/rscg_cordic.sv
hw/rtl/rotary_sin_cos_generator.sv
verif/rotary_sin_cos_generator_test.sv
